>>> rtl/ger_pkg.sv
// Shared types and constants for the glue EMA restart decision block.
// Used by the controller, datapath and top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ger_pkg;

	localparam int COUNT_WIDTH_DEF   = 48;
	localparam int EXTENSION_CAP_DEF = 8;

	localparam int GLUE_W = 24;
	localparam int VAR_W  = 32;
	localparam int EXT_W  = 4;
	localparam int CFG_W  = 16;
	localparam int IDX_W  = 2;
	localparam int PROD_W = 66;
	localparam int NUM_W  = 56;

	localparam logic [IDX_W-1:0] CFG_RESTART_ENABLE = 2'd0;
	localparam logic [IDX_W-1:0] CFG_FAST_WINDOW    = 2'd1;
	localparam logic [IDX_W-1:0] CFG_MARGIN_PERCENT = 2'd2;

	localparam logic [15:0] FAST_WINDOW_RST    = 16'd33;
	localparam logic [6:0]  MARGIN_PERCENT_RST = 7'd10;

	localparam logic [GLUE_W-1:0] ONE_Q16   = 24'h010000;
	localparam logic [GLUE_W-1:0] TWO_Q16   = 24'h020000;
	localparam logic [GLUE_W-1:0] GLUE_MAX  = 24'hFFFFFF;
	localparam logic [VAR_W-1:0]  TURB_VAR  = 32'd229376;
	localparam logic [32:0]       ONE_Q32   = 33'h100000000;
	localparam logic [32:0]       TINY_Q32  = 33'd4;
	localparam logic [31:0]       VAR_RECIP = 32'hCCCCCCCD;

	localparam logic [2:0] MUL_R_B   = 3'd0;
	localparam logic [2:0] MUL_B_B   = 3'd1;
	localparam logic [2:0] MUL_PF_D  = 3'd2;
	localparam logic [2:0] MUL_DIFF  = 3'd3;
	localparam logic [2:0] MUL_RECIP = 3'd4;

	localparam logic [1:0] DIV_BASE = 2'd0;
	localparam logic [1:0] DIV_EST  = 2'd1;

	typedef struct packed {
		logic       load;
		logic       res_early;
		logic       seed;
		logic       delta_en;
		logic       est_pass;
		logic       div_start;
		logic [1:0] div_sel;
		logic       base_take;
		logic [2:0] mul_sel;
		logic       r_take;
		logic       b_take;
		logic       num_en;
		logic       est_fix;
		logic       est_div_take;
		logic       var_prep;
		logic       var_take;
		logic       decide;
	} ger_cmd_t;

	typedef struct packed {
		logic early;
		logic delta_zero;
		logic pw_last;
		logic est_need_div;
		logic div_done;
	} ger_status_t;

endpackage
`default_nettype wire

>>> rtl/ger_div.sv
// Restoring divider, one quotient bit per cycle, 32 quotient bits.
// Standalone unit used by the datapath; no package dependencies.
`timescale 1ns / 1ps
`default_nettype none
module ger_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [32:0] rem0,
	input  wire logic [31:0] low,
	input  wire logic [32:0] divisor,
	output logic             done,
	output logic [31:0]      quotient
);
	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [32:0] rem_q;
	logic [31:0] quo_q;
	logic [32:0] div_q;
	logic [33:0] trial;
	logic        fits;

	assign trial = {rem_q, quo_q[31]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem0;
			quo_q <= low;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? 33'(trial - {1'b0, div_q}) : trial[32:0];
			quo_q <= {quo_q[30:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule
`default_nettype wire

>>> rtl/ger_ctrl.sv
// Sequencing state machine for the restart decision.
// Depends on ger_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none
module ger_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               out_stall,
	input  wire ger_pkg::ger_status_t st,
	output ger_pkg::ger_cmd_t       cmd,
	output logic                    in_stall,
	output logic                    out_valid
);
	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_CHECK  = 5'd1;
	localparam logic [4:0] S_DELTA  = 5'd2;
	localparam logic [4:0] S_BASE   = 5'd3;
	localparam logic [4:0] S_BASEW  = 5'd4;
	localparam logic [4:0] S_PA     = 5'd5;
	localparam logic [4:0] S_PB     = 5'd6;
	localparam logic [4:0] S_PC     = 5'd7;
	localparam logic [4:0] S_NEG    = 5'd8;
	localparam logic [4:0] S_NUM    = 5'd9;
	localparam logic [4:0] S_ESTCHK = 5'd10;
	localparam logic [4:0] S_ESTW   = 5'd11;
	localparam logic [4:0] S_SQ     = 5'd12;
	localparam logic [4:0] S_VPREP  = 5'd13;
	localparam logic [4:0] S_VMUL   = 5'd14;
	localparam logic [4:0] S_VTAKE  = 5'd15;
	localparam logic [4:0] S_DECIDE = 5'd16;
	localparam logic [4:0] S_OUT    = 5'd17;

	logic [4:0] state_q;
	logic [4:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				if (st.early) begin
					cmd.res_early = 1'b1;
					state_d       = S_OUT;
				end else begin
					cmd.seed = 1'b1;
					state_d  = S_DELTA;
				end
			end
			S_DELTA: begin
				cmd.delta_en = 1'b1;
				state_d      = S_BASE;
			end
			S_BASE: begin
				if (st.delta_zero) begin
					cmd.est_pass = 1'b1;
					state_d      = S_DECIDE;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = ger_pkg::DIV_BASE;
					state_d       = S_BASEW;
				end
			end
			S_BASEW: begin
				if (st.div_done) begin
					cmd.base_take = 1'b1;
					state_d       = S_PA;
				end
			end
			S_PA: begin
				cmd.mul_sel = ger_pkg::MUL_R_B;
				state_d     = S_PB;
			end
			S_PB: begin
				cmd.r_take  = 1'b1;
				cmd.mul_sel = ger_pkg::MUL_B_B;
				state_d     = S_PC;
			end
			S_PC: begin
				cmd.b_take = 1'b1;
				state_d    = st.pw_last ? S_NEG : S_PA;
			end
			S_NEG: begin
				cmd.mul_sel = ger_pkg::MUL_PF_D;
				state_d     = S_NUM;
			end
			S_NUM: begin
				cmd.num_en = 1'b1;
				state_d    = S_ESTCHK;
			end
			S_ESTCHK: begin
				cmd.est_fix = 1'b1;
				if (st.est_need_div) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = ger_pkg::DIV_EST;
					state_d       = S_ESTW;
				end else begin
					state_d = S_SQ;
				end
			end
			S_ESTW: begin
				if (st.div_done) begin
					cmd.est_div_take = 1'b1;
					state_d          = S_SQ;
				end
			end
			S_SQ: begin
				cmd.mul_sel = ger_pkg::MUL_DIFF;
				state_d     = S_VPREP;
			end
			S_VPREP: begin
				cmd.var_prep = 1'b1;
				state_d      = S_VMUL;
			end
			S_VMUL: begin
				cmd.mul_sel = ger_pkg::MUL_RECIP;
				state_d     = S_VTAKE;
			end
			S_VTAKE: begin
				cmd.var_take = 1'b1;
				state_d      = S_DECIDE;
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = S_OUT;
			end
			S_OUT: begin
				if (!out_stall) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign in_stall  = state_q != S_IDLE;
	assign out_valid = state_q == S_OUT;
endmodule
`default_nettype wire

>>> rtl/ger_dp.sv
// Datapath: configuration, history state, shared multiplier and divider.
// Depends on ger_pkg and instantiates ger_div.
`timescale 1ns / 1ps
`default_nettype none
module ger_dp #(
	parameter int COUNT_WIDTH   = ger_pkg::COUNT_WIDTH_DEF,
	parameter int EXTENSION_CAP = ger_pkg::EXTENSION_CAP_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [ger_pkg::IDX_W-1:0]     cfg_index,
	input  wire logic [ger_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic [COUNT_WIDTH-1:0]        conflict_count,
	input  wire logic [COUNT_WIDTH-1:0]        restart_limit,
	input  wire logic                          level_nonzero,
	input  wire logic                          stable_mode,
	input  wire logic                          reluctant_fire,
	input  wire logic [ger_pkg::GLUE_W-1:0]    fast_avg,
	input  wire logic [ger_pkg::GLUE_W-1:0]    slow_avg,
	input  wire ger_pkg::ger_cmd_t             cmd,
	output ger_pkg::ger_status_t               st,
	output logic                               do_restart
);
	logic        enable_q;
	logic [15:0] window_q;
	logic [6:0]  margin_q;

	logic [COUNT_WIDTH-1:0]     conf_q;
	logic [COUNT_WIDTH-1:0]     lim_q;
	logic                       level_q;
	logic                       stable_q;
	logic                       reluct_q;
	logic [ger_pkg::GLUE_W-1:0] fast_q;
	logic [ger_pkg::GLUE_W-1:0] slow_q;

	logic [ger_pkg::VAR_W-1:0]  var_q;
	logic [ger_pkg::GLUE_W-1:0] prev_fast_q;
	logic [COUNT_WIDTH-1:0]     prev_conf_q;
	logic [ger_pkg::EXT_W-1:0]  ext_q;

	logic [15:0]                delta_q;
	logic [31:0]                b_q;
	logic [32:0]                r_q;
	logic [3:0]                 pw_cnt_q;
	logic [ger_pkg::PROD_W-1:0] prod_q;
	logic [ger_pkg::NUM_W-1:0]  num_q;
	logic [32:0]                inv_q;
	logic                       nonpos_q;
	logic                       tiny_q;
	logic [ger_pkg::GLUE_W-1:0] est_q;
	logic                       var_neg_q;
	logic [30:0]                var_u_q;
	logic                       res_q;

	logic                       exit0;
	logic [COUNT_WIDTH-1:0]     delta_full;
	logic [32:0]                mul_a;
	logic [32:0]                mul_b;
	logic [ger_pkg::GLUE_W-1:0] diff;
	logic [ger_pkg::NUM_W-1:0]  pos;
	logic                       est_sat;
	logic [ger_pkg::GLUE_W-1:0] est_raw;
	logic [32:0]                div_rem0;
	logic [31:0]                div_low;
	logic [32:0]                div_divisor;
	logic                       div_done;
	logic [31:0]                div_quo;
	logic [31:0]                sq_val;
	logic                       var_neg;
	logic [32:0]                var_mag;
	logic [31:0]                var_quo;
	logic [32:0]                var_new;
	logic                       laminar;
	logic                       turbulent;
	logic                       standard;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
			window_q <= ger_pkg::FAST_WINDOW_RST;
			margin_q <= ger_pkg::MARGIN_PERCENT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				ger_pkg::CFG_RESTART_ENABLE: enable_q <= cfg_data[0];
				ger_pkg::CFG_FAST_WINDOW:    window_q <= cfg_data;
				ger_pkg::CFG_MARGIN_PERCENT: margin_q <= cfg_data[6:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			conf_q   <= conflict_count;
			lim_q    <= restart_limit;
			level_q  <= level_nonzero;
			stable_q <= stable_mode;
			reluct_q <= reluctant_fire;
			fast_q   <= fast_avg;
			slow_q   <= slow_avg;
		end
	end

	assign exit0      = !enable_q || !level_q || (conf_q < lim_q);
	assign delta_full = conf_q - prev_conf_q;
	assign diff       = (est_q >= fast_q) ? est_q - fast_q : fast_q - est_q;
	assign pos        = {fast_q, 32'd0};

	// The new variance is var + floor((sq - var) / 20); the division by 20 is a
	// shift by two and a reciprocal multiplication by one fifth.
	assign sq_val  = prod_q[47:16];
	assign var_neg = sq_val < var_q;
	assign var_mag = var_neg ? ({1'b0, var_q - sq_val} + 33'd19) : {1'b0, sq_val - var_q};
	assign var_quo = prod_q[65:34];
	assign var_new = var_neg_q ? ({1'b0, var_q} - {1'b0, var_quo})
		: ({1'b0, var_q} + {1'b0, var_quo});

	always_comb begin
		case (cmd.mul_sel)
			ger_pkg::MUL_R_B: begin
				mul_a = r_q;
				mul_b = {1'b0, b_q};
			end
			ger_pkg::MUL_B_B: begin
				mul_a = {1'b0, b_q};
				mul_b = {1'b0, b_q};
			end
			ger_pkg::MUL_PF_D: begin
				mul_a = {9'd0, prev_fast_q};
				mul_b = r_q;
			end
			ger_pkg::MUL_DIFF: begin
				mul_a = {9'd0, diff};
				mul_b = {9'd0, diff};
			end
			ger_pkg::MUL_RECIP: begin
				mul_a = {2'd0, var_u_q};
				mul_b = {1'b0, ger_pkg::VAR_RECIP};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	always_comb begin
		case (cmd.div_sel)
			ger_pkg::DIV_BASE: begin
				div_rem0    = {17'd0, window_q - 16'd1};
				div_low     = '0;
				div_divisor = {17'd0, window_q};
			end
			ger_pkg::DIV_EST: begin
				div_rem0    = {9'd0, num_q[55:32]};
				div_low     = num_q[31:0];
				div_divisor = inv_q;
			end
			default: begin
				div_rem0    = '0;
				div_low     = '0;
				div_divisor = 33'd1;
			end
		endcase
	end

	ger_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.rem0     (div_rem0),
		.low      (div_low),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign est_sat = {1'b0, num_q} >= {inv_q, 24'd0};
	assign est_raw = tiny_q ? fast_q : (nonpos_q ? ger_pkg::ONE_Q16 : ger_pkg::GLUE_MAX);

	always_ff @(posedge clk) begin
		if (cmd.delta_en) begin
			delta_q <= (delta_full[COUNT_WIDTH-1:16] != '0) ? 16'hFFFF : delta_full[15:0];
		end
		if (cmd.base_take) begin
			b_q <= (window_q == 16'd0) ? 32'd0 : div_quo;
			r_q <= ger_pkg::ONE_Q32;
		end
		if (cmd.r_take && delta_q[pw_cnt_q]) begin
			r_q <= prod_q[64:32];
		end
		if (cmd.b_take) begin
			b_q <= prod_q[63:32];
		end
		if (cmd.num_en) begin
			nonpos_q <= pos <= prod_q[55:0];
			num_q    <= pos - prod_q[55:0];
			inv_q    <= ger_pkg::ONE_Q32 - r_q;
			tiny_q   <= (ger_pkg::ONE_Q32 - r_q) <= ger_pkg::TINY_Q32;
		end
		if (cmd.est_pass) begin
			est_q <= fast_q;
		end
		if (cmd.est_fix) begin
			est_q <= (est_raw < ger_pkg::ONE_Q16) ? ger_pkg::ONE_Q16 : est_raw;
		end
		if (cmd.est_div_take) begin
			est_q <= (div_quo[23:0] < ger_pkg::ONE_Q16) ? ger_pkg::ONE_Q16 : div_quo[23:0];
		end
		if (cmd.var_prep) begin
			var_neg_q <= var_neg;
			var_u_q   <= var_mag[32:2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pw_cnt_q <= '0;
		end else if (cmd.base_take) begin
			pw_cnt_q <= '0;
		end else if (cmd.b_take) begin
			pw_cnt_q <= pw_cnt_q + 4'd1;
		end
	end

	assign laminar   = ({2'd0, fast_q} << 2) < ({2'd0, slow_q} + {1'b0, slow_q, 1'b0})
		&& (var_q < 32'(ger_pkg::ONE_Q16));
	assign turbulent = (28'(fast_q) * 28'd10 > 28'(slow_q) * 28'd11)
		&& (var_q > ger_pkg::TURB_VAR);
	assign standard  = (32'(8'd100 + {1'b0, margin_q}) * 32'(slow_q))
		<= (32'(fast_q) * 32'd100);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			var_q       <= '0;
			prev_fast_q <= '0;
			prev_conf_q <= '0;
			ext_q       <= '0;
		end else begin
			if (cmd.seed && prev_conf_q == '0) begin
				prev_fast_q <= fast_q;
				prev_conf_q <= conf_q;
			end
			if (cmd.var_take) begin
				var_q       <= var_new[32] ? 32'hFFFFFFFF : var_new[31:0];
				prev_fast_q <= fast_q;
				prev_conf_q <= conf_q;
			end
			if (cmd.decide && standard && laminar) begin
				if (est_q <= ger_pkg::TWO_Q16) begin
					ext_q <= '0;
				end else if (ext_q < ger_pkg::EXT_W'(EXTENSION_CAP)) begin
					ext_q <= ext_q + 4'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_early) begin
			res_q <= exit0 ? 1'b0 : reluct_q;
		end
		if (cmd.decide) begin
			if (standard) begin
				res_q <= !(laminar && ((est_q <= ger_pkg::TWO_Q16)
					|| (ext_q < ger_pkg::EXT_W'(EXTENSION_CAP))));
			end else begin
				res_q <= turbulent;
			end
		end
	end

	assign st.early        = exit0 || stable_q;
	assign st.delta_zero   = delta_q == 16'd0;
	assign st.pw_last      = pw_cnt_q == 4'd15;
	assign st.est_need_div = !tiny_q && !nonpos_q && !est_sat;
	assign st.div_done     = div_done;
	assign do_restart      = res_q;
endmodule
`default_nettype wire

>>> rtl/glue_ema_restart_decision_top.sv
// Top level of the glue EMA restart decision block.
// Depends on ger_pkg; instantiates ger_ctrl and ger_dp.
//
//   channel   direction  handshake             payload
//   in        input      in_valid / in_stall   conflict_count .. slow_avg
//   out       output     out_valid / out_stall do_restart
//   cfg       input      cfg_we                cfg_index, cfg_data
//
// One item is in flight at a time. An early exit or stable-mode item goes straight from the
// check to the result beat, and a focused item with no elapsed conflicts skips the divides
// and the multiplier. Other focused items run the 32-step base divide and the 16-round
// square-and-multiply on the shared multiplier, and the 32-step estimate divide when the
// estimate needs it. The next input beat can come in the cycle after the result beat;
// in_stall stays high until the result beat has been taken, so output stalls delay the
// next input beat. Reset clears control state and history and returns the
// configuration registers to their defaults.
`timescale 1ns / 1ps
`default_nettype none
module glue_ema_restart_decision_top #(
	parameter int COUNT_WIDTH   = ger_pkg::COUNT_WIDTH_DEF,
	parameter int EXTENSION_CAP = ger_pkg::EXTENSION_CAP_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [ger_pkg::IDX_W-1:0]  cfg_index,
	input  wire logic [ger_pkg::CFG_W-1:0]  cfg_data,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [COUNT_WIDTH-1:0]     conflict_count,
	input  wire logic [COUNT_WIDTH-1:0]     restart_limit,
	input  wire logic                       level_nonzero,
	input  wire logic                       stable_mode,
	input  wire logic                       reluctant_fire,
	input  wire logic [ger_pkg::GLUE_W-1:0] fast_avg,
	input  wire logic [ger_pkg::GLUE_W-1:0] slow_avg,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic                            do_restart
);
	ger_pkg::ger_cmd_t    cmd;
	ger_pkg::ger_status_t st;

	ger_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_stall (out_stall),
		.st        (st),
		.cmd       (cmd),
		.in_stall  (in_stall),
		.out_valid (out_valid)
	);

	ger_dp #(
		.COUNT_WIDTH   (COUNT_WIDTH),
		.EXTENSION_CAP (EXTENSION_CAP)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.conflict_count (conflict_count),
		.restart_limit  (restart_limit),
		.level_nonzero  (level_nonzero),
		.stable_mode    (stable_mode),
		.reluctant_fire (reluctant_fire),
		.fast_avg       (fast_avg),
		.slow_avg       (slow_avg),
		.cmd            (cmd),
		.st             (st),
		.do_restart     (do_restart)
	);
endmodule
`default_nettype wire

>>> tb/sv/glue_ema_restart_decision_top_test.sv
// Testbench for glue_ema_restart_decision_top: a directed set of checks and then random
// check items under several register settings; results are compared with a built-in predictor.
// Depends on ger_pkg and the RTL of the block.
`timescale 1ns / 1ps
module glue_ema_restart_decision_top_test;

	localparam int CW = ger_pkg::COUNT_WIDTH_DEF;
	localparam int GW = ger_pkg::GLUE_W;
	localparam int IW = ger_pkg::IDX_W;
	localparam int DW = ger_pkg::CFG_W;
	localparam longint unsigned CYCLE_LIMIT = 3_000_000;

	typedef struct {
		logic [CW-1:0] conflict_count;
		logic [CW-1:0] restart_limit;
		logic          level_nonzero;
		logic          stable_mode;
		logic          reluctant_fire;
		logic [GW-1:0] fast_avg;
		logic [GW-1:0] slow_avg;
	} check_item_t;

	class restart_scoreboard;
		bit        restart_q[$];
		int        errors;
		bit        en;
		bit [15:0] window;
		bit [6:0]  margin;
		bit [63:0] var_avg;
		bit [63:0] prev_fast;
		bit [63:0] prev_conf;
		bit [3:0]  ext_cnt;

		function new();
			en = 1'b1;
			window = ger_pkg::FAST_WINDOW_RST;
			margin = ger_pkg::MARGIN_PERCENT_RST;
			var_avg = 0;
			prev_fast = 0;
			prev_conf = 0;
			ext_cnt = 0;
			errors = 0;
		endfunction

		function void set_config(logic [IW-1:0] idx, logic [DW-1:0] val);
			case (idx)
				ger_pkg::CFG_RESTART_ENABLE: en = val[0];
				ger_pkg::CFG_FAST_WINDOW:    window = val;
				ger_pkg::CFG_MARGIN_PERCENT: margin = val[6:0];
				default: ;
			endcase
		endfunction

		function bit [63:0] decay_power(bit [63:0] w, bit [63:0] delta);
			bit [63:0] b;
			bit [63:0] r;
			b = (w == 0) ? 64'd0 : ((w - 1) << 32) / w;
			r = 64'h1_0000_0000;
			for (int i = 0; i < 16; i++) begin
				if (delta[i])
					r = (r * b) >> 32;
				b = (b * b) >> 32;
			end
			return r;
		endfunction

		function bit predict_restart(check_item_t it);
			bit [63:0] conf, lim, fast, slow, est, delta, d, inv, pos, neg, diff, sq, v;
			bit        lam, turb, std, res;
			conf = it.conflict_count;
			lim = it.restart_limit;
			fast = it.fast_avg;
			slow = it.slow_avg;
			if (!en || !it.level_nonzero || conf < lim)
				return 1'b0;
			if (it.stable_mode)
				return it.reluctant_fire;
			if (prev_conf == 0) begin
				prev_fast = fast;
				prev_conf = conf;
			end
			delta = (conf - prev_conf) & ((64'd1 << CW) - 1);
			est = fast;
			if (delta != 0) begin
				if (delta > 65535)
					delta = 65535;
				d = decay_power(window, delta);
				inv = 64'h1_0000_0000 - d;
				if (inv > 4) begin
					pos = fast << 32;
					neg = prev_fast * d;
					if (pos <= neg) begin
						est = ger_pkg::ONE_Q16;
					end else begin
						est = (pos - neg) / inv;
						if (est > ger_pkg::GLUE_MAX)
							est = ger_pkg::GLUE_MAX;
					end
				end
				if (est < ger_pkg::ONE_Q16)
					est = ger_pkg::ONE_Q16;
				diff = (est >= fast) ? est - fast : fast - est;
				sq = (diff * diff) >> 16;
				v = (var_avg * 19 + sq) / 20;
				if (v > 64'hFFFF_FFFF)
					v = 64'hFFFF_FFFF;
				var_avg = v;
				prev_fast = fast;
				prev_conf = conf;
			end
			lam = (4 * fast < 3 * slow) && (var_avg < ger_pkg::ONE_Q16);
			turb = (10 * fast > 11 * slow) && (var_avg > ger_pkg::TURB_VAR);
			std = (100 + 64'(margin)) * slow <= 100 * fast;
			if (std) begin
				res = 1'b1;
				if (lam) begin
					if (est <= ger_pkg::TWO_Q16) begin
						ext_cnt = 0;
						res = 1'b0;
					end else if (ext_cnt < ger_pkg::EXTENSION_CAP_DEF) begin
						ext_cnt = ext_cnt + 1;
						res = 1'b0;
					end
				end
			end else begin
				res = turb;
			end
			return res;
		endfunction

		function void note_input(check_item_t it);
			restart_q.push_back(predict_restart(it));
		endfunction

		function int pending();
			return restart_q.size();
		endfunction

		task report(string msg);
			$display("%0t mismatch: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(logic got);
			bit want;
			if (restart_q.size() == 0) begin
				report("result beat with nothing expected");
			end else begin
				want = restart_q.pop_front();
				if (got !== want)
					report($sformatf("do_restart %b, expected %b", got, want));
			end
		endtask
	endclass

	logic          clk = 1'b0;
	logic          arst_n;
	logic          cfg_we;
	logic [IW-1:0] cfg_index;
	logic [DW-1:0] cfg_data;
	logic          in_valid;
	logic          in_stall;
	logic [CW-1:0] conflict_count;
	logic [CW-1:0] restart_limit;
	logic          level_nonzero;
	logic          stable_mode;
	logic          reluctant_fire;
	logic [GW-1:0] fast_avg;
	logic [GW-1:0] slow_avg;
	logic          out_valid;
	logic          out_stall;
	logic          do_restart;

	restart_scoreboard sb = new();
	int                send_idle_pct = 0;
	int                recv_idle_pct = 0;
	logic [CW-1:0]     cur_conf = '0;
	longint unsigned   cycles = 0;

	glue_ema_restart_decision_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.conflict_count(conflict_count), .restart_limit(restart_limit),
		.level_nonzero(level_nonzero), .stable_mode(stable_mode),
		.reluctant_fire(reluctant_fire), .fast_avg(fast_avg), .slow_avg(slow_avg),
		.out_valid(out_valid), .out_stall(out_stall), .do_restart(do_restart)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("glue_ema_restart_decision_top_test: errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(do_restart);
		out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
	end

	task automatic write_cfg(logic [IW-1:0] idx, logic [DW-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_config(idx, val);
		@(posedge clk);
	endtask

	task automatic send_check(check_item_t it);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		conflict_count <= it.conflict_count;
		restart_limit <= it.restart_limit;
		level_nonzero <= it.level_nonzero;
		stable_mode <= it.stable_mode;
		reluctant_fire <= it.reluctant_fire;
		fast_avg <= it.fast_avg;
		slow_avg <= it.slow_avg;
		do @(posedge clk); while (in_stall);
		sb.note_input(it);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	function automatic check_item_t make_item(logic [CW-1:0] conf, logic [CW-1:0] lim,
			logic lvl, logic stb, logic rel, logic [GW-1:0] fst, logic [GW-1:0] slw);
		check_item_t it;
		it.conflict_count = conf;
		it.restart_limit = lim;
		it.level_nonzero = lvl;
		it.stable_mode = stb;
		it.reluctant_fire = rel;
		it.fast_avg = fst;
		it.slow_avg = slw;
		return it;
	endfunction

	function automatic logic [CW-1:0] rand_count();
		return CW'({$urandom, $urandom});
	endfunction

	function automatic check_item_t random_item();
		check_item_t   it;
		logic [CW-1:0] step;
		int            pick;
		int unsigned   slw;
		pick = $urandom_range(0, 99);
		if (pick < 80) begin
			case ($urandom_range(0, 19))
				0, 1:    step = '0;
				2:       step = CW'($urandom_range(65536, 1 << 20));
				3:       step = -CW'($urandom_range(1, 1000));
				4, 5, 6: step = CW'($urandom_range(51, 3000));
				default: step = CW'($urandom_range(1, 50));
			endcase
			cur_conf = cur_conf + step;
			slw = $urandom_range(16'h8000, 24'h0A0000);
			it = make_item(cur_conf, ($urandom_range(0, 3) == 0) ? cur_conf : CW'(0),
				1'b1, ($urandom_range(0, 9) == 0), $urandom_range(0, 1), 24'h0, 24'(slw));
			if ($urandom_range(0, 9) == 0)
				it.fast_avg = 24'($urandom);
			else
				it.fast_avg = 24'((64'(slw) * $urandom_range(50, 150)) / 100);
			if ($urandom_range(0, 9) == 0)
				it.slow_avg = 24'($urandom);
		end else begin
			it = make_item(rand_count(), ($urandom_range(0, 1) == 0) ? rand_count() : CW'(0),
				$urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
				24'($urandom), 24'($urandom));
		end
		return it;
	endfunction

	function automatic logic [15:0] pick_window();
		case ($urandom_range(0, 6))
			0: return 16'd0;
			1: return 16'd1;
			2: return 16'd2;
			3: return 16'hFFFF;
			4: return 16'd33;
			5: return 16'($urandom_range(3, 64));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_margin();
		case ($urandom_range(0, 4))
			0: return 16'd0;
			1: return 16'd100;
			2: return 16'd127;
			default: return 16'($urandom_range(0, 127));
		endcase
	endfunction

	localparam logic [CW-1:0] CMAX = {CW{1'b1}};

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= ger_pkg::CFG_RESTART_ENABLE;
		cfg_data <= '0;
		in_valid <= 1'b0;
		conflict_count <= '0;
		restart_limit <= '0;
		level_nonzero <= 1'b0;
		stable_mode <= 1'b0;
		reluctant_fire <= 1'b0;
		fast_avg <= '0;
		slow_avg <= '0;
		out_stall <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_check(make_item(0, CMAX, 1, 0, 0, 24'h010000, 24'h010000));
		send_check(make_item(100, 0, 0, 0, 1, 24'h020000, 24'h010000));
		send_check(make_item(CMAX, 0, 1, 1, 1, 24'h0, 24'h0));
		send_check(make_item(50, 40, 1, 1, 0, ger_pkg::GLUE_MAX, ger_pkg::GLUE_MAX));
		send_check(make_item(1000, 1000, 1, 0, 0, 24'h030000, 24'h028000));
		send_check(make_item(1000, 0, 1, 0, 0, 24'h030000, 24'h028000));
		send_check(make_item(1010, 0, 1, 0, 0, 24'h024000, 24'h030000));
		send_check(make_item(1040, 0, 1, 0, 0, ger_pkg::GLUE_MAX, 24'h010000));
		send_check(make_item(1041, 0, 1, 0, 0, 24'h0, ger_pkg::GLUE_MAX));
		send_check(make_item(900, 0, 1, 0, 0, 24'h018000, 24'h020000));
		send_check(make_item(200000, 0, 1, 0, 0, 24'h050000, 24'h020000));
		send_check(make_item(CMAX, 0, 1, 0, 1, ger_pkg::GLUE_MAX, 24'h0));
		send_check(make_item(CMAX, CMAX, 1, 0, 0, 24'h010000, 24'h0F0000));
		drain();
		write_cfg(ger_pkg::CFG_RESTART_ENABLE, 16'd0);
		send_check(make_item(5000, 0, 1, 1, 1, 24'h040000, 24'h010000));
		send_check(make_item(5001, 0, 1, 0, 0, 24'h040000, 24'h010000));
		drain();
		write_cfg(ger_pkg::CFG_RESTART_ENABLE, 16'd1);
		write_cfg(ger_pkg::CFG_FAST_WINDOW, 16'd1);
		write_cfg(ger_pkg::CFG_MARGIN_PERCENT, 16'd127);
		send_check(make_item(5010, 0, 1, 0, 0, 24'h040000, 24'h020000));
		send_check(make_item(5020, 0, 1, 0, 0, 24'h0A0000, 24'h020000));
		drain();
		write_cfg(ger_pkg::CFG_FAST_WINDOW, 16'hFFFF);
		write_cfg(ger_pkg::CFG_MARGIN_PERCENT, 16'd0);
		send_check(make_item(5030, 0, 1, 0, 0, 24'h040000, 24'h040000));
		send_check(make_item(70000, 0, 1, 0, 0, 24'h020000, 24'h040000));
		drain();
		cur_conf = CW'(70000);

		for (int chunk = 0; chunk < 18; chunk++) begin
			send_idle_pct = (chunk < 6) ? 28 : (chunk < 12) ? 82 : 0;
			recv_idle_pct = (chunk < 6) ? 82 : (chunk < 12) ? 28 : 0;
			write_cfg(ger_pkg::CFG_RESTART_ENABLE,
				($urandom_range(0, 7) == 0) ? 16'd0 : 16'd1);
			write_cfg(ger_pkg::CFG_FAST_WINDOW, pick_window());
			write_cfg(ger_pkg::CFG_MARGIN_PERCENT, pick_margin());
			for (int n = 0; n < 100; n++)
				send_check(random_item());
			drain();
		end

		repeat (200) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("glue_ema_restart_decision_top_test: clean");
		else
			$display("glue_ema_restart_decision_top_test: errors");
		$finish;
	end

endmodule
